FILE: sv/fcbp_pkg.sv
// Package: shared types, character codes and byte checks for the 8.3 name parser.
`timescale 1ns / 1ps

package fcbp_pkg;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_BLANK = 8'h20;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_Z  = 8'h7A;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_QUERY = 8'h3F;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CASE_MASK = 8'hDF;
	localparam logic [7:0] CH_HIGH  = 8'h80;

	localparam int NAME_LEN = 8;
	localparam int TYPE_LEN = 3;
	localparam int IDX_W    = 4;

	localparam logic [63:0] BLANK_NAME = {NAME_LEN{CH_BLANK}};
	localparam logic [23:0] BLANK_TYPE = {TYPE_LEN{CH_BLANK}};

	localparam int FCBP_QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		FS_SKIP,
		FS_HELD,
		FS_REPLAY,
		FS_RUN
	} front_state_t;

	typedef enum logic [2:0] {
		BP_NAME,
		BP_NAME_STAR,
		BP_TYPE,
		BP_TYPE_STAR,
		BP_IGNORE
	} back_phase_t;

	typedef enum logic [1:0] {
		OP_TAKE,
		OP_DRIVE,
		OP_END
	} op_kind_t;

	typedef struct packed {
		op_kind_t   kind;
		logic [7:0] ch;
		logic       wild;
	} op_t;

	// Flags a byte that may not stand in a name and returns it upper-cased.
	function automatic logic [8:0] check_byte(input logic [7:0] b, input logic wild);
		logic       bad;
		logic [7:0] v;
		bad = (b < CH_BLANK) || (b >= CH_HIGH);
		if (!wild && (b == CH_STAR || b == CH_QUERY))
			bad = 1'b1;
		v = b;
		if (b inside {[CH_LC_A:CH_LC_Z]})
			v = b - CH_BLANK;
		return {bad, v};
	endfunction

endpackage

FILE: sv/fcbp_queue.sv
// Small register queue between the front and back ends.
`timescale 1ns / 1ps

module fcbp_queue
	import fcbp_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = FCBP_QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             space,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             avail
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign space   = (count_q != CNT_FULL);
	assign avail   = (count_q != '0);
	assign dout    = mem_q[rd_ptr_q];
	assign do_push = push && space;
	assign do_pop  = pop && avail;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

FILE: sv/fcbp_front.sv
// Front end: skips leading blanks, spots a drive prefix and queues operations.
`timescale 1ns / 1ps

module fcbp_front
	import fcbp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] ch,
	input  logic       wildcards_ok,
	output logic       push,
	output op_t        push_op,
	input  logic       q_space
);

	front_state_t state_q;
	front_state_t state_d;
	logic [7:0]   held_q;
	logic         wild_q;
	logic         in_fire;

	assign in_ready = q_space && (state_q != FS_REPLAY);
	assign in_fire  = in_valid && in_ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			FS_SKIP: begin
				if (in_fire && ch != CH_NUL && ch != CH_BLANK)
					state_d = FS_HELD;
			end
			FS_HELD: begin
				if (in_fire)
					state_d = (ch == CH_COLON) ? FS_RUN : FS_REPLAY;
			end
			FS_REPLAY: begin
				if (q_space)
					state_d = (held_q == CH_NUL) ? FS_SKIP : FS_RUN;
			end
			FS_RUN: begin
				if (in_fire && ch == CH_NUL)
					state_d = FS_SKIP;
			end
			default: state_d = FS_SKIP;
		endcase
	end

	// outputs
	always_comb begin
		push         = 1'b0;
		push_op.kind = OP_TAKE;
		push_op.ch   = ch;
		push_op.wild = wild_q;
		case (state_q)
			FS_SKIP: begin
				push         = in_fire && (ch == CH_NUL);
				push_op.kind = OP_END;
				push_op.wild = wildcards_ok;
			end
			FS_HELD: begin
				push         = in_fire;
				push_op.kind = (ch == CH_COLON) ? OP_DRIVE : OP_TAKE;
				push_op.ch   = held_q;
			end
			FS_REPLAY: begin
				// second operation of the character after the first one
				push         = q_space;
				push_op.kind = (held_q == CH_NUL) ? OP_END : OP_TAKE;
				push_op.ch   = held_q;
			end
			FS_RUN: begin
				push         = in_fire;
				push_op.kind = (ch == CH_NUL) ? OP_END : OP_TAKE;
			end
			default: push = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_fire && (state_q == FS_SKIP || state_q == FS_HELD))
			held_q <= ch;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_SKIP;
			wild_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_fire && state_q == FS_SKIP)
				wild_q <= wildcards_ok;
		end
	end

endmodule

FILE: sv/fcbp_back.sv
// Back end: fills the name and type buffers and builds the result on the terminator.
`timescale 1ns / 1ps

module fcbp_back
	import fcbp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        op_valid,
	input  op_t         op,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        ok,
	output logic [4:0]  drive,
	output logic [63:0] base_name,
	output logic [23:0] extension
);

	localparam logic [IDX_W-1:0] NAME_LIM = IDX_W'(NAME_LEN);
	localparam logic [IDX_W-1:0] TYPE_LIM = IDX_W'(TYPE_LEN);

	back_phase_t       phase_q, phase_d;
	logic [IDX_W-1:0]  idx_q, idx_d;
	logic [63:0]       name_q, name_d;
	logic [23:0]       type_q, type_d;
	logic [4:0]        drive_q, drive_d;
	logic              err_q, err_d;

	logic              out_valid_q;
	logic              ok_q;
	logic [4:0]        drive_out_q;
	logic [63:0]       name_out_q;
	logic [23:0]       type_out_q;

	logic              out_free;
	logic              in_name;
	logic [IDX_W-1:0]  lim;
	logic [7:0]        d_up;
	logic              end_bad;
	logic [63:0]       name_chk;
	logic [23:0]       type_chk;
	logic [8:0]        chk;

	assign out_free = !out_valid_q || out_ready;
	assign pop      = op_valid && ((op.kind != OP_END) || out_free);
	assign in_name  = (phase_q == BP_NAME);
	assign lim      = in_name ? NAME_LIM : TYPE_LIM;
	assign d_up     = op.ch & CASE_MASK;

	// state update for one character or drive letter
	always_comb begin
		phase_d = phase_q;
		idx_d   = idx_q;
		name_d  = name_q;
		type_d  = type_q;
		drive_d = drive_q;
		err_d   = err_q;
		if (op.kind == OP_DRIVE) begin
			if (d_up inside {[CH_A:CH_P]}) begin
				drive_d = 5'(d_up - CH_A) + 5'd1;
			end else begin
				err_d   = 1'b1;
				phase_d = BP_IGNORE;
			end
		end else begin
			case (phase_q)
				BP_NAME, BP_TYPE: begin
					if (op.ch == CH_BLANK) begin
						phase_d = BP_IGNORE;
					end else if (in_name && op.ch == CH_DOT) begin
						phase_d = BP_TYPE;
						idx_d   = '0;
					end else if (op.wild && op.ch == CH_STAR) begin
						// fill the rest of the part with query marks
						for (int i = 0; i < NAME_LEN; i++)
							if (in_name && IDX_W'(i) >= idx_q)
								name_d[63-8*i -: 8] = CH_QUERY;
						for (int i = 0; i < TYPE_LEN; i++)
							if (!in_name && IDX_W'(i) >= idx_q)
								type_d[23-8*i -: 8] = CH_QUERY;
						idx_d   = lim;
						phase_d = in_name ? BP_NAME_STAR : BP_TYPE_STAR;
					end else if (idx_q >= lim) begin
						err_d   = 1'b1;
						phase_d = BP_IGNORE;
					end else begin
						for (int i = 0; i < NAME_LEN; i++)
							if (in_name && IDX_W'(i) == idx_q)
								name_d[63-8*i -: 8] = op.ch;
						for (int i = 0; i < TYPE_LEN; i++)
							if (!in_name && IDX_W'(i) == idx_q)
								type_d[23-8*i -: 8] = op.ch;
						idx_d = idx_q + 1'b1;
					end
				end
				BP_NAME_STAR: begin
					if (op.ch == CH_DOT) begin
						phase_d = BP_TYPE;
						idx_d   = '0;
					end else if (op.ch == CH_BLANK) begin
						phase_d = BP_IGNORE;
					end else begin
						err_d   = 1'b1;
						phase_d = BP_IGNORE;
					end
				end
				BP_TYPE_STAR: begin
					if (op.ch != CH_BLANK)
						err_d = 1'b1;
					phase_d = BP_IGNORE;
				end
				default: phase_d = phase_q;
			endcase
		end
	end

	// validate and upper-case the finished entry
	always_comb begin
		end_bad  = err_q || (name_q[63:56] == CH_BLANK);
		name_chk = '0;
		type_chk = '0;
		chk      = '0;
		for (int i = 0; i < NAME_LEN; i++) begin
			chk = check_byte(name_q[63-8*i -: 8], op.wild);
			name_chk[63-8*i -: 8] = chk[7:0];
			end_bad = end_bad || chk[8];
		end
		for (int i = 0; i < TYPE_LEN; i++) begin
			chk = check_byte(type_q[23-8*i -: 8], op.wild);
			type_chk[23-8*i -: 8] = chk[7:0];
			end_bad = end_bad || chk[8];
		end
	end

	always_ff @(posedge clk) begin
		if (pop && op.kind == OP_END) begin
			ok_q        <= !end_bad;
			drive_out_q <= end_bad ? '0 : drive_q;
			name_out_q  <= end_bad ? '0 : name_chk;
			type_out_q  <= end_bad ? '0 : type_chk;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= BP_NAME;
			idx_q       <= '0;
			name_q      <= BLANK_NAME;
			type_q      <= BLANK_TYPE;
			drive_q     <= '0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && op.kind == OP_END) begin
				// clear for the next name
				phase_q     <= BP_NAME;
				idx_q       <= '0;
				name_q      <= BLANK_NAME;
				type_q      <= BLANK_TYPE;
				drive_q     <= '0;
				err_q       <= 1'b0;
				out_valid_q <= 1'b1;
			end else begin
				if (pop) begin
					phase_q <= phase_d;
					idx_q   <= idx_d;
					name_q  <= name_d;
					type_q  <= type_d;
					drive_q <= drive_d;
					err_q   <= err_d;
				end
				if (out_ready)
					out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign ok        = ok_q;
	assign drive     = drive_out_q;
	assign base_name = name_out_q;
	assign extension = type_out_q;

endmodule

FILE: sv/filename_to_fcb_parser.sv
// Top level: streaming file name to 8.3 directory entry parser.
//
//  channel  | dir | transfer carries
//  ---------+-----+---------------------------------------------------------
//  s_*      | in  | one name character and the wildcard permission flag
//  m_*      | out | one parsed entry per terminator: ok, drive, name, type
//
// One character is taken per cycle while the queue has space. The character
// after a name's first non-blank one queues two operations unless it is the
// drive colon, and input waits while the second is queued. The back end
// handles one queued operation a cycle unless a terminator waits on a full
// output register. arst_n clears all control state at once. The operation
// queue lets the input run on while a finished entry waits on m_tready.
`timescale 1ns / 1ps

module filename_to_fcb_parser
	import fcbp_pkg::*;
#(
	parameter int QUEUE_DEPTH = FCBP_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [7:0] ch, [8] wildcards_ok, [15:9] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata   // [0] ok, [5:1] drive, [69:6] base_name,
	                              // [93:70] extension, [95:94] zero
);

	localparam int OP_W = $bits(op_t);

	logic            push;
	op_t             push_op;
	logic            q_space;
	logic            q_avail;
	logic            pop;
	logic [OP_W-1:0] q_dout;
	op_t             q_op;
	logic            ok;
	logic [4:0]      drive;
	logic [63:0]     base_name;
	logic [23:0]     extension;

	assign q_op = op_t'(q_dout);

	fcbp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.ch           (s_tdata[7:0]),
		.wildcards_ok (s_tdata[8]),
		.push         (push),
		.push_op      (push_op),
		.q_space      (q_space)
	);

	fcbp_queue #(
		.WIDTH (OP_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (OP_W'(push_op)),
		.space  (q_space),
		.pop    (pop),
		.dout   (q_dout),
		.avail  (q_avail)
	);

	fcbp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (q_avail),
		.op        (q_op),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.ok        (ok),
		.drive     (drive),
		.base_name (base_name),
		.extension (extension)
	);

	assign m_tdata = {2'b00, extension, base_name, drive, ok};

endmodule

FILE: dv/tb_filename_to_fcb_parser.sv
// Testbench: streams file names into the 8.3 parser and checks every entry it returns.
`timescale 1ns / 1ps

module tb_filename_to_fcb_parser;
	import fcbp_pkg::*;

	localparam int RANDOM_ITEMS = 1850;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int MAX_WAIT     = 13;
	localparam int SETTLE       = 30;
	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_LOW_BAD = 8'h1F;
	localparam logic [7:0] CH_SOH     = 8'h01;
	localparam logic [7:0] CH_DEL     = 8'h7F;
	localparam logic [7:0] CH_TOP     = 8'hFF;

	typedef enum logic [2:0] {
		P_SKIP,
		P_HELD,
		P_NAME,
		P_NAME_STAR,
		P_TYPE,
		P_TYPE_STAR,
		P_IGNORE
	} parse_phase_t;

	typedef struct packed {
		logic        ok;
		logic [4:0]  drive;
		logic [63:0] name;
		logic [23:0] ext;
	} entry_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [95:0] m_tdata;

	logic [15:0] pending_chars[$];
	entry_t      expected_entries[$];
	int          mismatches = 0;
	int unsigned cycles     = 0;
	int unsigned feed_wait  = 0;
	int unsigned drain_wait = 0;

	// Parser state as the block should hold it
	parse_phase_t parse_phase;
	logic [7:0]   first_char;
	int unsigned  part_pos;
	logic [7:0]   name_bytes[NAME_LEN];
	logic [7:0]   type_bytes[TYPE_LEN];
	logic [4:0]   drive_num;
	logic         parse_error;
	logic         wild_on;

	filename_to_fcb_parser DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic clear_parse();
		parse_phase = P_SKIP;
		first_char  = CH_NUL;
		part_pos    = 0;
		for (int i = 0; i < NAME_LEN; i++) name_bytes[i] = CH_BLANK;
		for (int i = 0; i < TYPE_LEN; i++) type_bytes[i] = CH_BLANK;
		drive_num   = '0;
		parse_error = 1'b0;
		wild_on     = 1'b0;
	endtask

	task automatic fail_parse();
		parse_error = 1'b1;
		parse_phase = P_IGNORE;
	endtask

	// One byte of the name or type part; never the terminator.
	task automatic place_char(input logic [7:0] c);
		logic        in_name;
		int unsigned lim;
		in_name = (parse_phase == P_NAME);
		lim     = in_name ? NAME_LEN : TYPE_LEN;
		case (parse_phase)
			P_NAME, P_TYPE: begin
				if (c == CH_BLANK) begin
					parse_phase = P_IGNORE;
				end else if (in_name && c == CH_DOT) begin
					parse_phase = P_TYPE;
					part_pos    = 0;
				end else if (wild_on && c == CH_STAR) begin
					// fill the rest of the part with query marks
					while (part_pos < lim) begin
						if (in_name) name_bytes[part_pos] = CH_QUERY;
						else type_bytes[part_pos] = CH_QUERY;
						part_pos++;
					end
					parse_phase = in_name ? P_NAME_STAR : P_TYPE_STAR;
				end else if (part_pos >= lim) begin
					fail_parse();
				end else begin
					if (in_name) name_bytes[part_pos] = c;
					else type_bytes[part_pos] = c;
					part_pos++;
				end
			end
			P_NAME_STAR: begin
				if (c == CH_DOT) begin
					parse_phase = P_TYPE;
					part_pos    = 0;
				end else if (c == CH_BLANK) begin
					parse_phase = P_IGNORE;
				end else begin
					fail_parse();
				end
			end
			P_TYPE_STAR: begin
				if (c == CH_BLANK) parse_phase = P_IGNORE;
				else fail_parse();
			end
			default: ;
		endcase
	endtask

	// Advance the parser by one accepted character; queue the entry on a terminator.
	task automatic parse_char(input logic [7:0] c, input logic w);
		logic       emit;
		logic       bad;
		logic [7:0] d;
		logic [7:0] b;
		entry_t     res;
		emit = 1'b0;
		if (parse_phase == P_SKIP) begin
			wild_on = w;
			if (c == CH_NUL) begin
				emit = 1'b1;
			end else if (c != CH_BLANK) begin
				first_char  = c;
				parse_phase = P_HELD;
			end
		end else if (parse_phase == P_HELD) begin
			parse_phase = P_NAME;
			part_pos    = 0;
			if (c == CH_COLON) begin
				d = first_char & CASE_MASK;
				if (d < CH_A || d > CH_P) fail_parse();
				else drive_num = 5'(d - CH_A + 8'd1);
			end else begin
				place_char(first_char);
				if (c != CH_NUL) place_char(c);
				else emit = 1'b1;
			end
		end else if (c != CH_NUL) begin
			place_char(c);
		end else begin
			emit = 1'b1;
		end

		if (emit) begin
			bad = parse_error || name_bytes[0] == CH_BLANK;
			res = '0;
			for (int i = 0; i < NAME_LEN + TYPE_LEN; i++) begin
				b = (i < NAME_LEN) ? name_bytes[i] : type_bytes[i - NAME_LEN];
				if (b < CH_BLANK || b >= CH_HIGH) bad = 1'b1;
				if (!wild_on && (b == CH_STAR || b == CH_QUERY)) bad = 1'b1;
				if (b >= CH_LC_A && b <= CH_LC_Z) b = b - CH_BLANK;
				if (i < NAME_LEN) res.name = {res.name[55:0], b};
				else res.ext = {res.ext[15:0], b};
			end
			res.ok    = !bad;
			res.drive = drive_num;
			if (bad) res = '0;
			expected_entries.push_back(res);
			clear_parse();
		end
	endtask

	task automatic queue_byte(input logic [7:0] c, input logic w);
		pending_chars.push_back({7'd0, w, c});
	endtask

	task automatic queue_name(input string text, input logic w);
		for (int i = 0; i < text.len(); i++) queue_byte(text[i], w);
		queue_byte(CH_NUL, w);
	endtask

	function automatic logic [7:0] name_byte();
		int unsigned r;
		r = $urandom_range(0, 49);
		if (r == 0) return CH_STAR;
		if (r == 1) return CH_QUERY;
		if (r == 2) return 8'($urandom_range(1, 255));
		if (r < 20) return 8'(CH_A + $urandom_range(0, 25));
		if (r < 38) return 8'(CH_LC_A + $urandom_range(0, 25));
		return 8'(CH_DIGIT_0 + $urandom_range(0, 9));
	endfunction

	task automatic queue_random_name();
		int unsigned n_lead;
		int unsigned n_name;
		int unsigned n_type;
		logic        w;
		logic [7:0]  c;
		w = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 99) < 15) begin
			// noise: any non-zero bytes, flag changing at will
			repeat ($urandom_range(0, 12))
				queue_byte(8'($urandom_range(1, 255)), 1'($urandom_range(0, 1)));
			queue_byte(CH_NUL, w);
			return;
		end
		n_lead = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
		repeat (n_lead) queue_byte(CH_BLANK, 1'($urandom_range(0, 1)));
		if ($urandom_range(0, 3) == 0) begin
			c = 8'(CH_A + $urandom_range(0, 15));
			if ($urandom_range(0, 1) == 1) c = c | CH_BLANK;
			if ($urandom_range(0, 9) == 0) c = 8'($urandom_range(1, 255));
			queue_byte(c, w);
			queue_byte(CH_COLON, w);
		end
		n_name = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 1) * 9 : $urandom_range(1, 8);
		repeat (n_name) queue_byte(name_byte(), w);
		if ($urandom_range(0, 9) < 7) begin
			queue_byte(CH_DOT, w);
			n_type = ($urandom_range(0, 11) == 0) ? 4 : $urandom_range(0, 3);
			repeat (n_type) queue_byte(name_byte(), w);
		end
		if ($urandom_range(0, 9) == 0) begin
			queue_byte(CH_BLANK, w);
			repeat ($urandom_range(0, 4)) queue_byte(8'($urandom_range(1, 255)), w);
		end
		queue_byte(CH_NUL, w);
	endtask

	// Sender: hold each character until its transfer, then idle a drawn number of cycles
	always @(posedge clk or negedge arst_n) begin : feed
		bit feed_calm;
		if (!arst_n) begin
			s_tvalid  <= 1'b0;
			s_tdata   <= '0;
			feed_wait <= 0;
		end else begin
			if ($urandom_range(0, 63) == 0) feed_calm = !feed_calm;
			if (s_tvalid && s_tready) parse_char(s_tdata[7:0], s_tdata[8]);
			if (!s_tvalid || s_tready) begin
				if (feed_wait != 0) begin
					s_tvalid  <= 1'b0;
					feed_wait <= feed_wait - 1;
				end else if (pending_chars.size() != 0) begin
					s_tvalid  <= 1'b1;
					s_tdata   <= pending_chars.pop_front();
					feed_wait <= feed_calm ? 0 : $urandom_range(0, MAX_WAIT);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: compare each entry transfer, then stall a drawn number of cycles
	always @(posedge clk or negedge arst_n) begin : drain
		bit          drain_calm;
		entry_t      got;
		entry_t      want;
		int unsigned w;
		if (!arst_n) begin
			m_tready   <= 1'b0;
			drain_wait <= 0;
		end else begin
			if ($urandom_range(0, 63) == 0) drain_calm = !drain_calm;
			if (m_tvalid && m_tready) begin
				got.ok    = m_tdata[0];
				got.drive = m_tdata[5:1];
				got.name  = m_tdata[69:6];
				got.ext   = m_tdata[93:70];
				if (expected_entries.size() == 0) begin
					$error("entry with no name pending: m_tdata %h", m_tdata);
					mismatches++;
				end else begin
					want = expected_entries.pop_front();
					if (got.ok !== want.ok) begin
						$error("ok: expected %0d, got %0d", want.ok, got.ok);
						mismatches++;
					end
					if (got.drive !== want.drive) begin
						$error("drive: expected %0d, got %0d", want.drive, got.drive);
						mismatches++;
					end
					if (got.name !== want.name) begin
						$error("base_name: expected %h, got %h", want.name, got.name);
						mismatches++;
					end
					if (got.ext !== want.ext) begin
						$error("extension: expected %h, got %h", want.ext, got.ext);
						mismatches++;
					end
				end
				w = drain_calm ? 0 : $urandom_range(0, MAX_WAIT);
				if (w == 0) begin
					m_tready <= 1'b1;
				end else begin
					m_tready   <= 1'b0;
					drain_wait <= w - 1;
				end
			end else if (!m_tready) begin
				if (drain_wait != 0) drain_wait <= drain_wait - 1;
				else m_tready <= 1'b1;
			end else if (!drain_calm && $urandom_range(0, 15) == 0) begin
				// drop ready while idle so stalls also hit the input side
				m_tready   <= 1'b0;
				drain_wait <= $urandom_range(0, MAX_WAIT);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned base;
		clear_parse();

		queue_name("", 1'b0);
		queue_name("   ", 1'b1);
		queue_name("  read.me", 1'b0);
		queue_name("b:file.c", 1'b0);
		queue_name("p:ABCDEFGH.XYZ", 1'b0);
		queue_name("Q:x", 1'b0);
		queue_name("@:x", 1'b1);
		queue_name("a:", 1'b0);
		queue_name("ABCDEFGHI", 1'b0);
		queue_name("a.bcde", 1'b0);
		queue_name("*.*", 1'b1);
		queue_name("ab*x", 1'b1);
		queue_name("ABCDEFGH*.c*", 1'b1);
		queue_name("a.b*z", 1'b1);
		queue_name("f?le.*", 1'b0);
		queue_name(".txt", 1'b0);
		queue_name("x", 1'b0);
		queue_name("name ext junk", 1'b0);
		queue_name("a.b.c", 1'b0);
		queue_name("z*  ", 1'b1);
		// flag counts only on the first non-blank character
		queue_byte(CH_BLANK, 1'b0);
		queue_byte(CH_STAR, 1'b1);
		queue_byte(CH_DOT, 1'b0);
		queue_byte(CH_STAR, 1'b0);
		queue_byte(CH_NUL, 1'b0);
		// bytes outside the printable range
		queue_byte(CH_A, 1'b0);
		queue_byte(CH_LOW_BAD, 1'b0);
		queue_byte(CH_NUL, 1'b0);
		queue_byte(CH_A, 1'b1);
		queue_byte(CH_HIGH, 1'b1);
		queue_byte(CH_NUL, 1'b1);
		queue_byte(CH_DEL, 1'b0);
		queue_byte(CH_NUL, 1'b0);
		queue_byte(CH_TOP, 1'b0);
		queue_byte(CH_SOH, 1'b0);
		queue_byte(CH_NUL, 1'b0);

		base = pending_chars.size();
		while (pending_chars.size() < base + RANDOM_ITEMS) queue_random_name();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_chars.size() != 0 || s_tvalid || expected_entries.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);

		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
